### rtl/core/iprtl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iprtl_pkg
// Shared constants and types for the address range table lookup core.
// ----------------------------------------------------------------------------
package iprtl_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_W     = SLOT_W + 1;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned REGION_W    = 32;
  localparam int unsigned STATUS_W    = 2;

  // Item opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Lookup status codes.
  localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BELOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd2;

  // One stored table entry.
  typedef struct packed {
    logic [ADDR_W-1:0]   first;
    logic [ADDR_W-1:0]   last;
    logic [REGION_W-1:0] region;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;        // store a load item into the table
    logic start;        // capture a lookup item and open the search window
    logic probe;        // read the first probed entry
    logic step;         // narrow the window and read the next entry
    logic load_result;  // move the final answer into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;   // the searched table is empty
    logic search_done;  // the current probe ends the search
  } dpath_status_t;

endpackage
`default_nettype wire

### rtl/core/iprtl_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iprtl_dpath
// Table memory, search window registers, probe compare and output register.
// ----------------------------------------------------------------------------
module iprtl_dpath (
  input  wire logic                             clk,
  input  wire iprtl_pkg::ctrl_cmd_t             cmd,
  output iprtl_pkg::dpath_status_t              status,
  input  wire logic                             range_count_we,
  input  wire logic [iprtl_pkg::COUNT_W-1:0]    range_count,
  input  wire logic                             rst,
  input  wire logic [iprtl_pkg::SLOT_W-1:0]     entry_slot,
  input  wire logic [iprtl_pkg::ADDR_W-1:0]     range_first,
  input  wire logic [iprtl_pkg::ADDR_W-1:0]     range_last,
  input  wire logic [iprtl_pkg::REGION_W-1:0]   region_code,
  input  wire logic [iprtl_pkg::ADDR_W-1:0]     query_address,
  output logic      [iprtl_pkg::STATUS_W-1:0]   lookup_status,
  output logic      [iprtl_pkg::SLOT_W-1:0]     found_slot,
  output logic      [iprtl_pkg::REGION_W-1:0]   found_region
);
  import iprtl_pkg::*;

  entry_t               mem [TABLE_DEPTH];
  entry_t               rd_data;
  logic [COUNT_W-1:0]   count_reg;
  logic [COUNT_W-1:0]   count_sat;
  logic [SLOT_W-1:0]    lo;
  logic [SLOT_W-1:0]    hi;
  logic [SLOT_W-1:0]    idx;
  logic                 lo_seen;
  logic                 hi_seen;
  logic                 empty;
  logic [ADDR_W-1:0]    query;
  logic [SLOT_W-1:0]    idx_next;
  logic [SLOT_W-1:0]    gap_lo;
  logic [SLOT_W-1:0]    gap_hi;
  logic                 is_below;
  logic                 is_above;
  logic                 end_below;
  logic                 end_above;
  logic [STATUS_W-1:0]  res_status;
  logic [REGION_W-1:0]  res_region;

  // Entry count register; the user must write it only while the core is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
    end else if (range_count_we) begin
      count_reg <= range_count;
    end
  end

  // Counts beyond the table depth search the whole table.
  assign count_sat = (count_reg > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count_reg;

  // Table memory: one write port for loads, one registered read port for probes.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[entry_slot] <= '{first: range_first, last: range_last, region: region_code};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      rd_data <= mem[idx];
    end else if (cmd.step) begin
      rd_data <= mem[idx_next];
    end
  end

  // Probe compare against the entry read for the current index.
  assign is_below  = query < rd_data.first;
  assign is_above  = !is_below && (query > rd_data.last);
  assign gap_lo    = idx - lo;
  assign gap_hi    = hi - idx;
  assign end_below = (gap_lo == '0) || ((gap_lo == SLOT_W'(1)) && lo_seen);
  assign end_above = (gap_hi == '0) || ((gap_hi == SLOT_W'(1)) && hi_seen);

  assign status.count_zero  = empty;
  assign status.search_done = (!is_below && !is_above) || (is_below && end_below) ||
                              (is_above && end_above);

  // Next probe index; a window of width one steps onto its far edge.
  always_comb begin
    if (is_below) begin
      idx_next = (gap_lo == SLOT_W'(1)) ? lo : idx - (gap_lo >> 1);
    end else begin
      idx_next = (gap_hi == SLOT_W'(1)) ? hi : idx + (gap_hi >> 1);
    end
  end

  // Search window registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      query   <= query_address;
      empty   <= (count_sat == '0);
      lo      <= '0;
      hi      <= SLOT_W'(count_sat - COUNT_W'(1));
      idx     <= SLOT_W'(count_sat >> 1);
      lo_seen <= 1'b0;
      hi_seen <= 1'b0;
    end else if (cmd.step) begin
      if (is_below) begin
        hi      <= idx;
        hi_seen <= 1'b1;
      end else begin
        lo      <= idx;
        lo_seen <= 1'b1;
      end
      idx <= idx_next;
    end
  end

  // Final answer of the search, or of an empty table.
  always_comb begin
    if (empty) begin
      res_status = ST_BELOW;
      res_region = '0;
    end else if (is_below) begin
      res_status = ST_BELOW;
      res_region = '0;
    end else if (is_above) begin
      res_status = ST_ABOVE;
      res_region = '0;
    end else begin
      res_status = ST_HIT;
      res_region = rd_data.region;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      lookup_status <= res_status;
      found_slot    <= empty ? '0 : idx;
      found_region  <= res_region;
    end
  end

endmodule
`default_nettype wire

### rtl/core/iprtl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iprtl_ctrl
// Controller that sequences loads, search probes and the output transfer.
// ----------------------------------------------------------------------------
module iprtl_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     opcode,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  input  wire iprtl_pkg::dpath_status_t status,
  output iprtl_pkg::ctrl_cmd_t          cmd
);
  import iprtl_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PROBE  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_xfer;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  // The output register can take a new answer when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (opcode == OP_LOOKUP) begin
            cmd.start  = 1'b1;
            state_next = S_PROBE;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (status.count_zero) begin
          if (out_free) begin
            cmd.load_result = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.probe  = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.search_done) begin
          if (out_free) begin
            cmd.load_result = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set by a new answer, cleared by a completed transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ip_range_table_lookup_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ip_range_table_lookup_core
// Address range table with a halving search lookup.
// ----------------------------------------------------------------------------
// A load item writes one table entry in the cycle it is accepted and gives no
// result. A lookup item searches the first range_count entries, which must be
// sorted by first address, and gives one result. The search reads one table
// entry per cycle from a single registered read port. A lookup captures the
// query, reads the first probed entry and then one entry per probe step until
// the search ends; the answer then moves into the output register once that
// register is free. An empty table answers without reading any entry. Only
// one lookup is in flight at a time; loads are taken while an earlier answer
// still waits at the output.
// ----------------------------------------------------------------------------
module ip_range_table_lookup_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             range_count_we,
  input  wire logic [iprtl_pkg::COUNT_W-1:0]    range_count,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             opcode,
  input  wire logic [iprtl_pkg::SLOT_W-1:0]     entry_slot,
  input  wire logic [iprtl_pkg::ADDR_W-1:0]     range_first,
  input  wire logic [iprtl_pkg::ADDR_W-1:0]     range_last,
  input  wire logic [iprtl_pkg::REGION_W-1:0]   region_code,
  input  wire logic [iprtl_pkg::ADDR_W-1:0]     query_address,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [iprtl_pkg::STATUS_W-1:0]   lookup_status,
  output logic      [iprtl_pkg::SLOT_W-1:0]     found_slot,
  output logic      [iprtl_pkg::REGION_W-1:0]   found_region
);
  import iprtl_pkg::*;

  ctrl_cmd_t     cmd;
  dpath_status_t status;

  // Controller.
  iprtl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  iprtl_dpath u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .range_count_we (range_count_we),
    .range_count    (range_count),
    .rst            (rst),
    .entry_slot     (entry_slot),
    .range_first    (range_first),
    .range_last     (range_last),
    .region_code    (region_code),
    .query_address  (query_address),
    .lookup_status  (lookup_status),
    .found_slot     (found_slot),
    .found_region   (found_region)
  );

endmodule
`default_nettype wire

### dv/ip_range_table_lookup_core_tb.sv
// ----------------------------------------------------------------------------
// ip_range_table_lookup_core_tb
// Self-checking bench for the address range table lookup core.
// ----------------------------------------------------------------------------
// A short directed plan covers the empty table, the first and last addresses,
// hits, misses on both sides, gaps between ranges and an unsorted table. Then
// randomized phases load a sorted table of some size or reuse the last one, set
// range_count while the core is idle, and mix lookups aimed at range edges and
// gaps with stray loads. Each answer is checked against a behavioral search in
// the bench or one given in the plan. Both sides idle or stall at random.
// ----------------------------------------------------------------------------
module ip_range_table_lookup_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iprtl_pkg::*;

  // Cycles to let the core settle before a register write, and at the end.
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned DRAIN_CYCLES  = 30;
  // Hard stop for the whole run, in ns.
  localparam longint unsigned WATCHDOG_NS = 64'd10_000_000;

  // One input transfer, all fields.
  typedef struct packed {
    logic                op;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   first;
    logic [ADDR_W-1:0]   last;
    logic [REGION_W-1:0] region;
    logic [ADDR_W-1:0]   addr;
  } range_item_t;

  // One lookup answer.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [REGION_W-1:0] region;
  } lookup_answer_t;

  // Rows of the directed plan.
  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_FIND, ROW_FIND_KNOWN} plan_kind_e;

  typedef struct {
    plan_kind_e     kind;
    int unsigned    slot;    // table slot for a load, register value for a write
    logic [31:0]    first;
    logic [31:0]    last;
    logic [31:0]    region;
    logic [31:0]    addr;
    lookup_answer_t answer;  // used by ROW_FIND_KNOWN only
  } plan_row_t;

  // Directed plan. The count is zero out of reset.
  plan_row_t directed_plan [25] = '{
    '{ROW_FIND_KNOWN, 0, '0, '0, '0, 32'h0000_0000, {ST_BELOW, 10'd0, 32'd0}},
    '{ROW_FIND_KNOWN, 0, '0, '0, '0, 32'hFFFF_FFFF, {ST_BELOW, 10'd0, 32'd0}},
    '{ROW_LOAD, 0, 32'h0000_0000, 32'h0000_00FF, 32'hFFFF_FFFF, '0, '0},
    '{ROW_LOAD, 1, 32'h0000_0200, 32'h0000_02FF, 32'h0000_0000, '0, '0},
    '{ROW_LOAD, 2, 32'h0000_1000, 32'h0000_1FFF, 32'h1234_5678, '0, '0},
    '{ROW_LOAD, 3, 32'h8000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, '0, '0},
    '{ROW_LOAD, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_5A5A, '0, '0},
    '{ROW_CFG, 1, '0, '0, '0, '0, '0},
    '{ROW_FIND_KNOWN, 0, '0, '0, '0, 32'h0000_0000, {ST_HIT, 10'd0, 32'hFFFF_FFFF}},
    '{ROW_FIND_KNOWN, 0, '0, '0, '0, 32'h0000_0100, {ST_ABOVE, 10'd0, 32'd0}},
    '{ROW_CFG, 4, '0, '0, '0, '0, '0},
    '{ROW_FIND, 0, '0, '0, '0, 32'h0000_0250, '0},
    '{ROW_FIND, 0, '0, '0, '0, 32'h0000_0100, '0},
    '{ROW_FIND, 0, '0, '0, '0, 32'h0000_0500, '0},
    '{ROW_FIND_KNOWN, 0, '0, '0, '0, 32'hFFFF_FFFF, {ST_HIT, 10'd3, 32'hA5A5_A5A5}},
    '{ROW_FIND, 0, '0, '0, '0, 32'h7FFF_FFFF, '0},
    '{ROW_FIND, 0, '0, '0, '0, 32'h0000_0000, '0},
    '{ROW_CFG, 2, '0, '0, '0, '0, '0},
    '{ROW_FIND, 0, '0, '0, '0, 32'h0000_0300, '0},
    // Break the order: slot 2 now starts below slot 1.
    '{ROW_LOAD, 2, 32'h0000_0010, 32'h0000_0020, 32'h0000_0077, '0, '0},
    '{ROW_CFG, 3, '0, '0, '0, '0, '0},
    '{ROW_FIND, 0, '0, '0, '0, 32'h0000_0018, '0},
    '{ROW_FIND, 0, '0, '0, '0, 32'h0000_1500, '0},
    '{ROW_CFG, 0, '0, '0, '0, '0, '0},
    '{ROW_FIND_KNOWN, 0, '0, '0, '0, 32'h0000_0250, {ST_BELOW, 10'd0, 32'd0}}
  };

  // DUT ports.
  logic                clk = 1'b0;
  logic                rst;
  logic                range_count_we;
  logic [COUNT_W-1:0]  range_count;
  logic                in_valid;
  logic                in_stall;
  logic                opcode;
  logic [SLOT_W-1:0]   entry_slot;
  logic [ADDR_W-1:0]   range_first;
  logic [ADDR_W-1:0]   range_last;
  logic [REGION_W-1:0] region_code;
  logic [ADDR_W-1:0]   query_address;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] lookup_status;
  logic [SLOT_W-1:0]   found_slot;
  logic [REGION_W-1:0] found_region;

  // Shadow copy of the table and the count register.
  logic [ADDR_W-1:0]   shadow_first  [TABLE_DEPTH];
  logic [ADDR_W-1:0]   shadow_last   [TABLE_DEPTH];
  logic [REGION_W-1:0] shadow_region [TABLE_DEPTH];
  logic [COUNT_W-1:0]  shadow_count = '0;

  // Answers still owed by the core, oldest first.
  lookup_answer_t pending_answers [$];
  lookup_answer_t want;

  // Run statistics.
  int unsigned mismatch_count  = 0;
  int unsigned transfers_in    = 0;
  int unsigned lookups_checked = 0;
  int unsigned hit_total       = 0;
  int unsigned miss_total      = 0;
  int unsigned count_writes    = 0;
  int unsigned largest_table   = 0;
  bit          calm            = 1'b0;

  ip_range_table_lookup_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .range_count_we (range_count_we),
    .range_count    (range_count),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .entry_slot     (entry_slot),
    .range_first    (range_first),
    .range_last     (range_last),
    .region_code    (region_code),
    .query_address  (query_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .lookup_status  (lookup_status),
    .found_slot     (found_slot),
    .found_region   (found_region)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Random idle decision shared by both sides; never idle in a calm stretch.
  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 24);
  endfunction

  // Halving search over the shadow table, with gap and bound handling.
  function automatic lookup_answer_t predict_lookup(input logic [ADDR_W-1:0] addr);
    int unsigned    n;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    idx;
    bit             lo_seen;
    bit             hi_seen;
    lookup_answer_t ans;
    n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
    ans.region = '0;
    if (n == 0) begin
      ans.status = ST_BELOW;
      ans.slot   = '0;
      return ans;
    end
    lo = 0;
    hi = n - 1;
    idx = n / 2;
    lo_seen = 1'b0;
    hi_seen = 1'b0;
    for (int guard = 0; guard < 4 * TABLE_DEPTH + 8; guard++) begin
      ans.slot = idx[SLOT_W-1:0];
      if (addr < shadow_first[idx]) begin
        // Address lies below this range: move toward lower slots.
        hi = idx;
        hi_seen = 1'b1;
        if (idx == lo || (idx - lo == 1 && lo_seen)) begin
          ans.status = ST_BELOW;
          return ans;
        end
        idx = (idx - lo == 1) ? lo : idx - (idx - lo) / 2;
      end else if (addr > shadow_last[idx]) begin
        // Address lies above this range: move toward higher slots.
        lo = idx;
        lo_seen = 1'b1;
        if (hi == idx || (hi - idx == 1 && hi_seen)) begin
          ans.status = ST_ABOVE;
          return ans;
        end
        idx = (hi - idx == 1) ? hi : idx + (hi - idx) / 2;
      end else begin
        ans.status = ST_HIT;
        ans.region = shadow_region[idx];
        return ans;
      end
    end
    ans.slot   = idx[SLOT_W-1:0];
    ans.status = ST_ABOVE;
    return ans;
  endfunction

  // Load transfer; the unused lookup field carries noise.
  function automatic range_item_t load_item(input int unsigned slot,
                                            input logic [31:0] first, last, region);
    range_item_t it;
    it.op     = OP_LOAD;
    it.slot   = slot[SLOT_W-1:0];
    it.first  = first;
    it.last   = last;
    it.region = region;
    it.addr   = $urandom();
    return it;
  endfunction

  // Lookup transfer; the unused load fields carry noise.
  function automatic range_item_t find_item(input logic [31:0] addr);
    range_item_t it;
    it.op     = OP_LOOKUP;
    it.slot   = $urandom_range(TABLE_DEPTH - 1);
    it.first  = $urandom();
    it.last   = $urandom();
    it.region = $urandom();
    it.addr   = addr;
    return it;
  endfunction

  // Present one transfer, wait for it to be taken, then update the shadow
  // table or queue the answer the core owes.
  task automatic push_item(input range_item_t it, input bit known,
                           input lookup_answer_t typed);
    lookup_answer_t ans;
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= it.op;
    entry_slot    <= it.slot;
    range_first   <= it.first;
    range_last    <= it.last;
    region_code   <= it.region;
    query_address <= it.addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transfers_in++;
    if (it.op == OP_LOAD) begin
      shadow_first[it.slot]  = it.first;
      shadow_last[it.slot]   = it.last;
      shadow_region[it.slot] = it.region;
    end else begin
      ans = known ? typed : predict_lookup(it.addr);
      pending_answers.push_back(ans);
      if (ans.status == ST_HIT) hit_total++;
      else miss_total++;
    end
  endtask

  // Drop valid and wait until every owed answer has come back.
  task automatic drain_core();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // Write range_count once the core has gone quiet.
  task automatic set_range_count(input int unsigned value);
    drain_core();
    repeat (SETTLE_CYCLES) @(negedge clk);
    range_count_we <= 1'b1;
    range_count    <= value[COUNT_W-1:0];
    shadow_count    = value[COUNT_W-1:0];
    count_writes++;
    @(negedge clk);
    range_count_we <= 1'b0;
  endtask

  // Load slots 0..n-1 with ascending ranges, some touching, most with gaps.
  task automatic build_table(input int unsigned n);
    longint unsigned stride;
    longint unsigned upper;
    longint unsigned span;
    logic [31:0]     starts [TABLE_DEPTH];
    logic [31:0]     stop;
    if (n == 0) return;
    stride = (64'd1 << 32) / n;
    for (int unsigned i = 0; i < n; i++) begin
      starts[i] = 32'(i * stride + $urandom_range(32'(stride / 4)));
    end
    if ($urandom_range(1) == 0) starts[0] = '0;
    for (int unsigned i = 0; i < n; i++) begin
      upper = (i == n - 1) ? (64'd1 << 32) : longint'(starts[i + 1]);
      span  = upper - starts[i];
      if ($urandom_range(3) == 0) stop = 32'(starts[i] + span - 1);
      else stop = starts[i] + $urandom_range(32'(span - 1));
      push_item(load_item(i, starts[i], stop, $urandom()), 1'b0, '0);
    end
  endtask

  // Compare one answer field and report it if it is among the first ten mismatches.
  task automatic check_field(input string name, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      end
    end
  endtask

  // Check answers as they are taken.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: answer with none owed: status %0d slot %0d region %h",
                   $time, lookup_status, found_slot, found_region);
        end
      end else begin
        want = pending_answers.pop_front();
        lookups_checked++;
        check_field("lookup_status", 32'(want.status), 32'(lookup_status));
        check_field("found_slot", 32'(want.slot), 32'(found_slot));
        check_field("found_region", want.region, found_region);
      end
    end
  end

  // Output side stalls at random, except in calm stretches.
  always @(negedge clk) begin
    out_stall <= take_break();
  end

  // Stimulus.
  initial begin
    int unsigned     table_sizes [$];
    int unsigned     built_size;
    int unsigned     eff;
    int unsigned     finds;
    int unsigned     k;
    int unsigned     pick;
    logic [31:0]     addr;
    plan_row_t       row;

    rst            = 1'b1;
    range_count_we = 1'b0;
    range_count    = '0;
    in_valid       = 1'b0;
    opcode         = OP_LOAD;
    entry_slot     = '0;
    range_first    = '0;
    range_last     = '0;
    region_code    = '0;
    query_address  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed plan.
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      case (row.kind)
        ROW_CFG: begin
          set_range_count(row.slot);
        end
        ROW_LOAD: begin
          push_item(load_item(row.slot, row.first, row.last, row.region), 1'b0, '0);
        end
        default: begin
          push_item(find_item(row.addr), row.kind == ROW_FIND_KNOWN, row.answer);
        end
      endcase
    end

    // Random phases: small tables mostly, one full table reused with an
    // oversized count and with one entry short.
    table_sizes = '{0, 1, 2};
    repeat (8) table_sizes.push_back($urandom_range(3, 32));
    table_sizes.push_back(TABLE_DEPTH);
    table_sizes.push_back((1 << COUNT_W) - 1);
    table_sizes.push_back(TABLE_DEPTH - 1);
    repeat (2) table_sizes.push_back($urandom_range(3, 32));
    built_size = 0;

    foreach (table_sizes[p]) begin
      eff = (table_sizes[p] > TABLE_DEPTH) ? TABLE_DEPTH : table_sizes[p];
      calm = (p == 5) || (table_sizes[p] > TABLE_DEPTH);
      if (eff > built_size || eff <= 64) begin
        build_table(eff);
        built_size = eff;
      end
      set_range_count(table_sizes[p]);
      if (eff > largest_table) largest_table = eff;
      finds = (eff == TABLE_DEPTH && table_sizes[p] == TABLE_DEPTH) ? 120 :
              (eff > 64) ? 60 : (eff == 0) ? 15 : 30;

      // Lookups aimed at range interiors and edges, with stray loads.
      for (int unsigned f = 0; f < finds; f++) begin
        if ($urandom_range(99) < 6) begin
          push_item(load_item($urandom_range(TABLE_DEPTH - 1), $urandom(), $urandom(),
                              $urandom()), 1'b0, '0);
        end else begin
          pick = $urandom_range(99);
          if (eff == 0 || pick >= 85) begin
            addr = $urandom();
          end else begin
            k = $urandom_range(eff - 1);
            if (pick < 45) begin
              addr = (shadow_last[k] >= shadow_first[k]) ?
                     shadow_first[k] + $urandom_range(shadow_last[k] - shadow_first[k]) :
                     shadow_first[k];
            end else if (pick < 65) begin
              addr = shadow_first[k] - 1;
            end else begin
              addr = shadow_last[k] + 1;
            end
          end
          push_item(find_item(addr), 1'b0, '0);
        end
      end
    end
    calm = 1'b0;

    // Wind down and report.
    drain_core();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Took %0d transfers in and checked %0d answers (%0d hits, %0d misses).",
             transfers_in, lookups_checked, hit_total, miss_total);
    $display("Searched tables of up to %0d entries over %0d count settings.",
             largest_table, count_writes);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(WATCHDOG_NS);
    $display("Timed out with %0d answers still owed.", pending_answers.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

### ip_range_table_lookup_core.f
rtl/core/iprtl_pkg.sv
rtl/core/iprtl_dpath.sv
rtl/core/iprtl_ctrl.sv
rtl/core/ip_range_table_lookup_core.sv
dv/ip_range_table_lookup_core_tb.sv
